// File: hw/rtl/mfs_pkg.sv
// Shared types and constants for the message framer / segmenter.
// Used by mfs_front, mfs_cmd_fifo, mfs_back and the top level.
package mfs_pkg;

  localparam int unsigned SIZE_BITS   = 20;
  localparam int unsigned FRAME_BITS  = 16;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned HDR_WORDS   = 5;
  localparam int unsigned POS_BITS    = 5;

  localparam logic [FRAME_BITS-1:0] MIN_FRAME      = 16'd21;
  localparam logic [FRAME_BITS-1:0] CHUNK_HDR_ALL  = 16'd20;  // outer 8 + chunk 12
  localparam logic [FRAME_BITS:0]   CHUNK_EXTRA    = 17'd12;
  localparam logic [FRAME_BITS-1:0] RST_FRAME_SIZE = 16'd1024;

  localparam logic [POS_BITS-1:0] PLAIN_LEN = 5'd8;
  localparam logic [POS_BITS-1:0] CHUNK_LEN = 5'd20;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_FRAME  = 2'd0;
  localparam logic [1:0] REG_BYTE_ORDER = 2'd1;
  localparam logic [1:0] REG_CHUNK_TYPE = 2'd2;

  localparam logic ACT_BEGIN   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_NO_MSG   = 2'd1;
  localparam logic [1:0] FAULT_REOPENED = 2'd2;

  typedef enum logic [1:0] {
    HDR_NONE  = 2'd0,
    HDR_PLAIN = 2'd1,
    HDR_CHUNK = 2'd2
  } hdr_kind_t;

  // One unit of work for the back end: an optional byte, then an optional header.
  typedef struct packed {
    logic                               has_byte;
    logic [7:0]                         data;
    logic                               byte_end;
    hdr_kind_t                          hdr;
    logic                               hdr_end;   // empty message: header closes frame
    logic [1:0]                         fault;
    logic [HDR_WORDS-1:0][WORD_BITS-1:0] words;
  } cmd_t;

endpackage

// File: hw/rtl/mfs_front.sv
// Front end: configuration registers, message state, item classification.
// Emits one mfs_pkg::cmd_t per accepted item. Depends on mfs_pkg.
module mfs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           action,
  input  logic [31:0]                    msg_type,
  input  logic [mfs_pkg::SIZE_BITS-1:0]  msg_size,
  input  logic [7:0]                     payload_byte,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_addr,
  input  logic [31:0]                    cfg_data,
  input  logic                           q_full,
  output logic                           q_push,
  output mfs_pkg::cmd_t                  q_cmd,
  output logic                           byte_order
);

  logic [mfs_pkg::FRAME_BITS-1:0] max_frame_size;
  logic [31:0]                    chunk_type_code;

  logic                           open, open_next;
  logic                           segmented, segmented_next;
  logic [31:0]                    held_type, held_type_next;
  logic [mfs_pkg::SIZE_BITS-1:0]  bytes_remaining, bytes_remaining_next;
  logic [mfs_pkg::SIZE_BITS-1:0]  chunk_number, chunk_number_next;
  logic [mfs_pkg::FRAME_BITS-1:0] chunk_bytes_left, chunk_bytes_left_next;

  logic [mfs_pkg::FRAME_BITS-1:0] frame_eff;
  logic [mfs_pkg::FRAME_BITS-1:0] cap;
  logic [mfs_pkg::FRAME_BITS:0]   cap_plus;
  logic [mfs_pkg::SIZE_BITS-1:0]  br_dec;
  logic [mfs_pkg::FRAME_BITS-1:0] cbl_dec;
  logic [mfs_pkg::SIZE_BITS-1:0]  cn_inc;
  logic [mfs_pkg::FRAME_BITS-1:0] n_next;
  mfs_pkg::cmd_t                  cmd;

  assign q_push = push && !q_full;
  assign q_cmd  = cmd;

  assign frame_eff = (max_frame_size < mfs_pkg::MIN_FRAME) ? mfs_pkg::MIN_FRAME : max_frame_size;
  assign cap       = frame_eff - mfs_pkg::CHUNK_HDR_ALL;
  assign cap_plus  = {1'b0, cap} + mfs_pkg::CHUNK_EXTRA;
  assign br_dec    = bytes_remaining - 1'b1;
  assign cbl_dec   = chunk_bytes_left - 1'b1;
  assign cn_inc    = chunk_number + 1'b1;
  assign n_next    = (br_dec < {4'b0, cap}) ? br_dec[mfs_pkg::FRAME_BITS-1:0] : cap;

  always_comb begin
    open_next             = open;
    segmented_next        = segmented;
    held_type_next        = held_type;
    bytes_remaining_next  = bytes_remaining;
    chunk_number_next     = chunk_number;
    chunk_bytes_left_next = chunk_bytes_left;
    cmd                   = '0;
    cmd.hdr               = mfs_pkg::HDR_NONE;
    if (action == mfs_pkg::ACT_BEGIN) begin
      cmd.fault             = open ? mfs_pkg::FAULT_REOPENED : mfs_pkg::FAULT_NONE;
      held_type_next        = msg_type;
      bytes_remaining_next  = msg_size;
      chunk_number_next     = '0;
      chunk_bytes_left_next = '0;
      if (msg_size > {3'b0, cap_plus}) begin
        // first chunk is always full size
        segmented_next        = 1'b1;
        open_next             = 1'b1;
        chunk_bytes_left_next = cap;
        cmd.hdr               = mfs_pkg::HDR_CHUNK;
        cmd.words[0]          = chunk_type_code;
        cmd.words[1]          = {15'b0, cap_plus};
        cmd.words[2]          = msg_type;
        cmd.words[3]          = {16'b0, cap};
        cmd.words[4]          = '0;
      end else begin
        segmented_next = 1'b0;
        open_next      = (msg_size != '0);
        cmd.hdr        = mfs_pkg::HDR_PLAIN;
        cmd.hdr_end    = (msg_size == '0);
        cmd.words[0]   = msg_type;
        cmd.words[1]   = {12'b0, msg_size};
      end
    end else if (!open) begin
      cmd.has_byte = 1'b1;
      cmd.fault    = mfs_pkg::FAULT_NO_MSG;
    end else begin
      cmd.has_byte         = 1'b1;
      cmd.data             = payload_byte;
      bytes_remaining_next = br_dec;
      if (!segmented) begin
        cmd.byte_end = (br_dec == '0);
        open_next    = (br_dec != '0);
      end else begin
        chunk_bytes_left_next = cbl_dec;
        cmd.byte_end          = (cbl_dec == '0);
        if (cbl_dec == '0) begin
          if (br_dec == '0) begin
            open_next      = 1'b0;
            segmented_next = 1'b0;
          end else begin
            chunk_number_next     = cn_inc;
            chunk_bytes_left_next = n_next;
            cmd.hdr               = mfs_pkg::HDR_CHUNK;
            cmd.words[0]          = chunk_type_code;
            cmd.words[1]          = {16'b0, n_next} + {15'b0, mfs_pkg::CHUNK_EXTRA};
            cmd.words[2]          = held_type;
            cmd.words[3]          = {16'b0, n_next};
            cmd.words[4]          = {12'b0, cn_inc};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_size   <= mfs_pkg::RST_FRAME_SIZE;
      byte_order       <= 1'b0;
      chunk_type_code  <= '0;
      open             <= 1'b0;
      segmented        <= 1'b0;
      held_type        <= '0;
      bytes_remaining  <= '0;
      chunk_number     <= '0;
      chunk_bytes_left <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          mfs_pkg::REG_MAX_FRAME:  max_frame_size  <= cfg_data[mfs_pkg::FRAME_BITS-1:0];
          mfs_pkg::REG_BYTE_ORDER: byte_order      <= cfg_data[0];
          mfs_pkg::REG_CHUNK_TYPE: chunk_type_code <= cfg_data;
          default: ;
        endcase
      end
      if (q_push) begin
        open             <= open_next;
        segmented        <= segmented_next;
        held_type        <= held_type_next;
        bytes_remaining  <= bytes_remaining_next;
        chunk_number     <= chunk_number_next;
        chunk_bytes_left <= chunk_bytes_left_next;
      end
    end
  end

endmodule

// File: hw/rtl/mfs_cmd_fifo.sv
// Two-entry command queue between front and back ends.
// Depends on mfs_pkg for cmd_t.
module mfs_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  mfs_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output mfs_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);

  mfs_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/mfs_back.sv
// Back end: expands queued commands into frame bytes, one per cycle while
// the receiver keeps popping, into an output register. Depends on mfs_pkg.
module mfs_back (
  input  logic          clk,
  input  logic          rst,
  input  mfs_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic          byte_order,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    frame_byte,
  output logic          frame_end,
  output logic          last_of_run,
  output logic [1:0]    fault
);

  logic [mfs_pkg::POS_BITS-1:0] pos;
  logic [mfs_pkg::POS_BITS-1:0] hdr_len;
  logic [mfs_pkg::POS_BITS-1:0] last_pos;
  logic [mfs_pkg::POS_BITS-1:0] hpos;
  logic [1:0]                   lane;
  logic [31:0]                  word;
  logic                         out_valid;
  logic                         emit;
  logic                         is_last;
  logic [7:0]                   byte_sel;
  logic                         end_sel;

  assign empty   = !out_valid;
  assign emit    = !cmd_empty && (!out_valid || pop);
  assign is_last = (pos == last_pos);
  assign cmd_pop = emit && is_last;

  always_comb begin
    unique case (cmd.hdr)
      mfs_pkg::HDR_PLAIN: hdr_len = mfs_pkg::PLAIN_LEN;
      mfs_pkg::HDR_CHUNK: hdr_len = mfs_pkg::CHUNK_LEN;
      default:            hdr_len = '0;
    endcase
  end

  assign last_pos = hdr_len + {4'b0, cmd.has_byte} - 1'b1;
  assign hpos     = pos - {4'b0, cmd.has_byte};
  assign lane     = byte_order ? ~hpos[1:0] : hpos[1:0];

  always_comb begin
    case (hpos[4:2])
      3'd0:    word = cmd.words[0];
      3'd1:    word = cmd.words[1];
      3'd2:    word = cmd.words[2];
      3'd3:    word = cmd.words[3];
      3'd4:    word = cmd.words[4];
      default: word = '0;
    endcase
  end

  always_comb begin
    if (cmd.has_byte && pos == '0) begin
      byte_sel = cmd.data;
      end_sel  = cmd.byte_end;
    end else begin
      case (lane)
        2'd0:    byte_sel = word[7:0];
        2'd1:    byte_sel = word[15:8];
        2'd2:    byte_sel = word[23:16];
        default: byte_sel = word[31:24];
      endcase
      end_sel = cmd.hdr_end && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_byte  <= byte_sel;
      frame_end   <= end_sel;
      last_of_run <= is_last;
      fault       <= cmd.fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        pos       <= is_last ? '0 : pos + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/message_framer_segmenter_top.sv
// Message framer / segmenter: turns begin and payload items into framed bytes.
// Instantiates mfs_front, mfs_cmd_fifo and mfs_back; uses mfs_pkg.
//
// Input side is a queue: drive an item and raise push; it is taken at a clock
// edge where full is low. action 0 begins a message (msg_type, msg_size),
// action 1 carries one payload_byte.
// Output side is a queue: while empty is low the oldest result sits on
// frame_byte/frame_end/last_of_run/fault; pop takes it.
// Config: write cfg_data to register cfg_addr (0 max_frame_size, 1 byte_order,
// 2 chunk_type_code) with cfg_we, only while the block is idle.
// The first result of an item goes from the command queue into the output
// register once older commands are out and the previous result is popped.
// Throughput: while pop keeps up, the back end puts out one byte per cycle,
// so payload items run at one per cycle; a begin emits 8 bytes (20 chunked),
// a non-final chunk's last byte 21 with the next header. The two-entry command
// queue absorbs one item while a header goes out, then full rises.
// A stalled receiver stalls the back end, fills the queue and raises full.
// Reset clears queue, output register and message state and restores
// max_frame_size 1024, little-endian order and chunk type code 0.
module message_framer_segmenter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [31:0]                   msg_type,
  input  logic [mfs_pkg::SIZE_BITS-1:0] msg_size,
  input  logic [7:0]                    payload_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    frame_byte,
  output logic                          frame_end,
  output logic                          last_of_run,
  output logic [1:0]                    fault,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [31:0]                   cfg_data
);

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  mfs_pkg::cmd_t q_wr_cmd;
  mfs_pkg::cmd_t q_rd_cmd;
  logic          byte_order;

  assign full = q_full;

  mfs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .action       (action),
    .msg_type     (msg_type),
    .msg_size     (msg_size),
    .payload_byte (payload_byte),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_wr_cmd),
    .byte_order   (byte_order)
  );

  mfs_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_cmd (q_wr_cmd),
    .rd_en  (q_pop),
    .rd_cmd (q_rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  mfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (q_rd_cmd),
    .cmd_empty   (q_empty),
    .cmd_pop     (q_pop),
    .byte_order  (byte_order),
    .pop         (pop),
    .empty       (empty),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end),
    .last_of_run (last_of_run),
    .fault       (fault)
  );

endmodule
